// File: rtl/core/motor_command_link_with_retry_macros.svh
// Assertion macros for the motor command link.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MOTOR_COMMAND_LINK_WITH_RETRY_MACROS_SVH
`define MOTOR_COMMAND_LINK_WITH_RETRY_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define MCLR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mclr check failed");

// antecedent implies consequent in the next cycle
`define MCLR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mclr check failed");

`else

`define MCLR_ASSERT_IMP(label, clk, rst, ante, cons)
`define MCLR_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/mclr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the motor command link.
// No dependencies; used by mclr_queue and motor_command_link_with_retry.
package mclr_pkg;

  // motor command bytes on the wire
  localparam logic [7:0] CMD_FORWARD = 8'h11;
  localparam logic [7:0] CMD_STOP    = 8'h12;
  localparam logic [7:0] CMD_REVERSE = 8'h13;
  localparam logic [7:0] CHECKSUM_BASE = 8'h03;

  // enqueue command codes
  localparam logic [1:0] CODE_STOP    = 2'd0;
  localparam logic [1:0] CODE_FORWARD = 2'd1;
  localparam logic [1:0] CODE_REVERSE = 2'd2;
  localparam logic [1:0] CODE_NONE    = 2'd3;

  // word kinds on tuser
  localparam logic FUNC_ENQUEUE = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  // link mode codes reported on the result word
  localparam logic [1:0] LINK_MODE_RECEIVE = 2'd0;
  localparam logic [1:0] LINK_MODE_SEND    = 2'd1;
  localparam logic [1:0] LINK_MODE_WAIT    = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CODE      = 2'd2;

  localparam logic [7:0] TIMEOUT_RESET     = 8'd100;
  localparam logic [3:0] MAX_RETRIES_RESET = 4'd3;
  localparam logic [7:0] KEY_CODE_RESET    = 8'd0;

  // link state, one-hot
  typedef enum logic [1:0] {
    ST_RECEIVE = 2'b01,
    ST_WAIT    = 2'b10
  } link_state_t;

  // input word payload, last member in the lowest bits
  typedef struct packed {
    logic [7:0] rx_status;
    logic [7:0] rx_cmd;
    logic [7:0] rx_length;
    logic       rx_valid;
    logic [1:0] command;
  } link_in_t;

  // result word payload, last member in the lowest bits
  typedef struct packed {
    logic [7:0] last_length;
    logic [7:0] last_status;
    logic [7:0] last_cmd;
    logic       gave_up;
    logic       dropped;
    logic [4:0] queued;
    logic [3:0] resend_count;
    logic [1:0] link_mode;
    logic       key_report;
    logic [7:0] send_checksum;
    logic [7:0] send_cmd;
    logic       send_valid;
  } link_out_t;

  // queue request from the link machine, already qualified by item advance
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [1:0] code;
  } queue_req_t;

  // queued code to command byte; code 3 never gets stored, maps to stop
  function automatic logic [7:0] code_to_byte(input logic [1:0] code);
    logic [7:0] b;
    b = CMD_STOP;
    unique case (code)
      CODE_STOP:    b = CMD_STOP;
      CODE_FORWARD: b = CMD_FORWARD;
      CODE_REVERSE: b = CMD_REVERSE;
      default:      b = CMD_STOP;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/mclr_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mclr_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/mclr_queue.sv
`timescale 1ns / 1ps
// Transmit command queue: circular buffer that drops its oldest entry when full.
// Depends on mclr_pkg, mclr_ram and the assertion macro header.
`include "motor_command_link_with_retry_macros.svh"
module mclr_queue #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mclr_pkg::queue_req_t       req,
  output logic [1:0]                 head_code,
  output logic                       nonempty,
  output logic [$clog2(DEPTH+1)-1:0] fill_next,
  output logic                       drop
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int SW = AW + 2;

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [AW-1:0] head_inc;
  logic [FW-1:0] fill;
  logic          full;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail;
  logic [1:0]    ram_rdata;
  logic          byp;
  logic [1:0]    byp_data;

  assign full     = (fill == FW'(DEPTH));
  assign nonempty = (fill != '0);
  assign drop     = req.push && full;

  // head moves on a pop or when the oldest entry is pushed out
  assign head_inc  = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
  assign head_next = (req.pop || drop) ? head_inc : head;

  // write slot: head + fill wrapped once; when full this is the dropped slot
  assign tail_sum = SW'(head) + SW'(fill);
  assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

  always_comb begin
    fill_next = fill;
    if (req.push && !full) begin
      fill_next = fill + FW'(1);
    end else if (req.pop) begin
      fill_next = fill - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
      byp  <= 1'b0;
    end else begin
      head <= head_next;
      fill <= fill_next;
      byp  <= req.push && (tail == head_next);
    end
    byp_data <= req.code;
  end

  // read port always prefetches the next head entry
  mclr_ram #(
    .WIDTH (2),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (req.push),
    .waddr (tail),
    .wdata (req.code),
    .raddr (head_next),
    .rdata (ram_rdata)
  );

  // forward a word written into the slot that was being read
  assign head_code = byp ? byp_data : ram_rdata;

  `MCLR_ASSERT_IMP(a_fill_range, clk, rst, 1'b1, fill <= FW'(DEPTH))
  `MCLR_ASSERT_IMP(a_head_range, clk, rst, 1'b1, head <= AW'(DEPTH - 1))
  `MCLR_ASSERT_IMP(a_pop_nonempty, clk, rst, req.pop, fill != '0 && !req.push)

endmodule

// File: rtl/core/motor_command_link_with_retry.sv
`timescale 1ns / 1ps
// Motor command link with retry: top level, link state machine and result stage.
// Depends on mclr_pkg, mclr_queue and the assertion macro header.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser selects
//   the kind: 0 enqueues a command code, 1 is one link tick that may decode a
//   received packet, pop and send a queued command, or resend or give up on timeout.
//   Every input word produces exactly one result word on m_tvalid/m_tready/
//   m_tdata carrying the send fields, key pulse, link mode and counters.
//   A word accepted into the input register moves on to the result register,
//   where it raises m_tvalid. One word per cycle is sustained while m_tready
//   stays high: the link update is combinational and the queue RAM always
//   prefetches its head entry.
//   When m_tready is low the result word holds; one more word is taken into
//   the input register, after which s_tready drops until the result is taken.
//   Synchronous reset empties the queue (no clearing pass), returns the link
//   to receive mode, clears counters and decoded fields, and loads the
//   configuration defaults (timeout 100, retries 3, key code 0).
//   Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once.
`include "motor_command_link_with_retry_macros.svh"
module motor_command_link_with_retry #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // input words
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [1:0] command, [2] rx_valid, [10:3] rx_length, [18:11] rx_cmd,
  // [26:19] rx_status, [31:27] zero
  input  logic [31:0]                        s_tdata,
  // [0] func
  input  logic                               s_tuser,
  // result words
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [0] send_valid, [8:1] send_cmd, [16:9] send_checksum, [17] key_report,
  // [19:18] link_mode, [23:20] resend_count, [28:24] queued, [29] dropped,
  // [30] gave_up, [38:31] last_cmd, [46:39] last_status, [54:47] last_length,
  // [55] zero
  output logic [55:0]                        m_tdata,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [mclr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                         cfg_data
);

  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  // configuration
  logic [7:0] timeout_ticks;
  logic [3:0] max_retries;
  logic [7:0] key_code;

  // input register
  logic                 in_valid;
  logic                 in_func;
  mclr_pkg::link_in_t   in_q;

  // result register
  mclr_pkg::link_out_t  out_q;
  mclr_pkg::link_out_t  res;

  // link state
  mclr_pkg::link_state_t state, state_next;
  logic [7:0] pending_cmd, pending_cmd_next;
  logic [7:0] tick_count, tick_count_next;
  logic [3:0] resends, resends_next;
  logic [7:0] last_cmd, last_cmd_next;
  logic [7:0] last_status, last_status_next;
  logic [7:0] last_length, last_length_next;

  logic                    adv;
  logic                    send_valid;
  logic [7:0]              send_cmd;
  logic                    key_report;
  logic                    gave_up;
  logic [7:0]              pop_byte;
  mclr_pkg::queue_req_t    qreq;
  logic [1:0]              q_head_code;
  logic                    q_nonempty;
  logic [FW-1:0]           q_fill_next;
  logic                    q_drop;

  // handshake: the input stage moves on when the result register is free
  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= mclr_pkg::TIMEOUT_RESET;
      max_retries   <= mclr_pkg::MAX_RETRIES_RESET;
      key_code      <= mclr_pkg::KEY_CODE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mclr_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        mclr_pkg::REG_MAX_RETRIES:   max_retries   <= cfg_data[3:0];
        mclr_pkg::REG_KEY_CODE:      key_code      <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_func <= s_tuser;
      in_q    <= mclr_pkg::link_in_t'(s_tdata[$bits(mclr_pkg::link_in_t)-1:0]);
    end
  end

  assign pop_byte = mclr_pkg::code_to_byte(q_head_code);

  // link update for the word in the input register
  always_comb begin
    state_next       = state;
    pending_cmd_next = pending_cmd;
    tick_count_next  = tick_count;
    resends_next     = resends;
    last_cmd_next    = last_cmd;
    last_status_next = last_status;
    last_length_next = last_length;
    send_valid       = 1'b0;
    send_cmd         = 8'h00;
    key_report       = 1'b0;
    gave_up          = 1'b0;
    qreq.push        = 1'b0;
    qreq.pop         = 1'b0;
    qreq.code        = in_q.command;

    if (in_func == mclr_pkg::FUNC_ENQUEUE) begin
      qreq.push = adv && (in_q.command != mclr_pkg::CODE_NONE);
    end else begin
      // decode a received packet in receive and wait modes
      if (in_q.rx_valid &&
          (state == mclr_pkg::ST_RECEIVE || state == mclr_pkg::ST_WAIT)) begin
        last_cmd_next    = in_q.rx_cmd;
        last_status_next = in_q.rx_status;
        last_length_next = in_q.rx_length;
        key_report       = (in_q.rx_cmd == key_code);
      end
      unique case (state)
        mclr_pkg::ST_RECEIVE: begin
          if (q_nonempty) begin
            qreq.pop         = adv;
            pending_cmd_next = pop_byte;
            send_valid       = 1'b1;
            send_cmd         = pop_byte;
            state_next       = (pop_byte == mclr_pkg::CMD_STOP) ? mclr_pkg::ST_RECEIVE
                                                                : mclr_pkg::ST_WAIT;
          end
        end
        mclr_pkg::ST_WAIT: begin
          // matching acknowledgement ends the wait unless the timeout below still fires
          if (in_q.rx_valid && in_q.rx_cmd == pending_cmd) begin
            resends_next    = 4'd0;
            tick_count_next = 8'd0;
            state_next      = mclr_pkg::ST_RECEIVE;
          end
          tick_count_next = tick_count_next + 8'd1;
          // timeout: resend or give up
          if (tick_count_next >= timeout_ticks) begin
            tick_count_next = 8'd0;
            if (resends_next < max_retries) begin
              state_next   = mclr_pkg::ST_WAIT;
              resends_next = resends_next + 4'd1;
              send_valid   = 1'b1;
              send_cmd     = pending_cmd;
            end else begin
              state_next   = mclr_pkg::ST_RECEIVE;
              resends_next = 4'd0;
              gave_up      = 1'b1;
            end
          end
        end
        default: begin
          state_next = mclr_pkg::ST_RECEIVE;
        end
      endcase
    end
  end

  // result word
  always_comb begin
    res.send_valid    = send_valid;
    res.send_cmd      = send_cmd;
    res.send_checksum = send_valid ? 8'(send_cmd + mclr_pkg::CHECKSUM_BASE) : 8'h00;
    res.key_report    = key_report;
    res.link_mode     = (state_next == mclr_pkg::ST_WAIT) ? mclr_pkg::LINK_MODE_WAIT
                                                          : mclr_pkg::LINK_MODE_RECEIVE;
    res.resend_count  = resends_next;
    res.queued        = 5'(q_fill_next);
    res.dropped       = q_drop;
    res.gave_up       = gave_up;
    res.last_cmd      = last_cmd_next;
    res.last_status   = last_status_next;
    res.last_length   = last_length_next;
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= mclr_pkg::ST_RECEIVE;
      pending_cmd <= 8'h00;
      tick_count  <= 8'd0;
      resends     <= 4'd0;
      last_cmd    <= 8'h00;
      last_status <= 8'h00;
      last_length <= 8'h00;
      m_tvalid    <= 1'b0;
    end else begin
      if (adv) begin
        state       <= state_next;
        pending_cmd <= pending_cmd_next;
        tick_count  <= tick_count_next;
        resends     <= resends_next;
        last_cmd    <= last_cmd_next;
        last_status <= last_status_next;
        last_length <= last_length_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid    <= 1'b0;
      end
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_tdata = {1'b0, out_q};

  mclr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .req       (qreq),
    .head_code (q_head_code),
    .nonempty  (q_nonempty),
    .fill_next (q_fill_next),
    .drop      (q_drop)
  );

  `MCLR_ASSERT_IMP(a_wait_cmd, clk, rst, state == mclr_pkg::ST_WAIT,
                   pending_cmd == mclr_pkg::CMD_FORWARD || pending_cmd == mclr_pkg::CMD_REVERSE)
  `MCLR_ASSERT_IMP(a_gave_up_clean, clk, rst, m_tvalid && out_q.gave_up,
                   out_q.resend_count == 4'd0 && !out_q.send_valid &&
                   out_q.link_mode == mclr_pkg::LINK_MODE_RECEIVE)
  `MCLR_ASSERT_NXT(a_state_hold, clk, rst, !rst && !adv,
                   $stable(state) && $stable(tick_count) && $stable(resends))

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Testbench for motor_command_link_with_retry: directed and random word streams
// with random stalls on both sides, checked against an in-bench link model.
// Depends on mclr_pkg and the RTL top level only.
module testbench;

  localparam int          CYCLE_LIMIT = 600000;
  localparam int          PHASE_WORDS = 250;
  localparam logic [7:0]  PKT_LEN     = 8'h03;

  // tracks the link state and the result words still due
  class link_scoreboard;
    mclr_pkg::link_out_t due_results[$];
    logic [7:0]  timeout;
    logic [3:0]  retries;
    logic [7:0]  key;
    logic [1:0]  mode;
    logic [7:0]  pend_cmd;
    logic        waiting;
    logic [7:0]  ticks;
    logic [3:0]  resends;
    logic [1:0]  cmd_q [16];
    logic [3:0]  head;
    logic [4:0]  fill;
    logic [7:0]  last_len, last_cmd, last_st;
    int          errors, mismatches, words_in, words_out;
    int          n_sent, n_resent, n_acked, n_dropped, n_gave_up, n_keys;

    function new();
      timeout  = mclr_pkg::TIMEOUT_RESET;
      retries  = mclr_pkg::MAX_RETRIES_RESET;
      key      = mclr_pkg::KEY_CODE_RESET;
      mode     = mclr_pkg::LINK_MODE_RECEIVE;
      pend_cmd = '0;
      waiting  = 1'b0;
      ticks    = '0;
      resends  = '0;
      head     = '0;
      fill     = '0;
      last_len = '0;
      last_cmd = '0;
      last_st  = '0;
      foreach (cmd_q[i]) cmd_q[i] = mclr_pkg::CODE_STOP;
    endfunction

    function void write_reg(logic [mclr_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        mclr_pkg::REG_TIMEOUT_TICKS: timeout = val;
        mclr_pkg::REG_MAX_RETRIES:   retries = val[3:0];
        mclr_pkg::REG_KEY_CODE:      key = val;
        default: ;
      endcase
    endfunction

    // send the pending command; stop needs no ack
    function void transmit(inout mclr_pkg::link_out_t r);
      r.send_valid    = 1'b1;
      r.send_cmd      = pend_cmd;
      r.send_checksum = pend_cmd + mclr_pkg::CHECKSUM_BASE;
      if (pend_cmd == mclr_pkg::CMD_STOP) waiting = 1'b0;
      else if (pend_cmd == mclr_pkg::CMD_FORWARD || pend_cmd == mclr_pkg::CMD_REVERSE)
        waiting = 1'b1;
      mode = waiting ? mclr_pkg::LINK_MODE_WAIT : mclr_pkg::LINK_MODE_RECEIVE;
      n_sent++;
    endfunction

    function void decode(mclr_pkg::link_in_t w, inout mclr_pkg::link_out_t r);
      last_len = w.rx_length;
      last_cmd = w.rx_cmd;
      last_st  = w.rx_status;
      r.key_report = (w.rx_cmd == key);
      if (r.key_report) n_keys++;
    endfunction

    // one link step: returns the result word this input word produces
    function mclr_pkg::link_out_t advance_link(logic func, mclr_pkg::link_in_t w);
      mclr_pkg::link_out_t r;
      logic [3:0]          slot;
      r = '0;
      if (func == mclr_pkg::FUNC_ENQUEUE) begin
        if (w.command != mclr_pkg::CODE_NONE) begin
          // full queue loses its oldest entry
          if (fill >= 5'd16) begin
            head++;
            fill--;
            r.dropped = 1'b1;
            n_dropped++;
          end
          slot = head + fill[3:0];
          cmd_q[slot] = w.command;
          fill++;
        end
      end else begin
        case (mode)
          mclr_pkg::LINK_MODE_RECEIVE: begin
            if (w.rx_valid) decode(w, r);
            if (fill != 0) begin
              case (cmd_q[head])
                mclr_pkg::CODE_FORWARD: pend_cmd = mclr_pkg::CMD_FORWARD;
                mclr_pkg::CODE_REVERSE: pend_cmd = mclr_pkg::CMD_REVERSE;
                default:                pend_cmd = mclr_pkg::CMD_STOP;
              endcase
              head++;
              fill--;
              mode = mclr_pkg::LINK_MODE_SEND;
              transmit(r);
            end
          end
          mclr_pkg::LINK_MODE_SEND: transmit(r);
          mclr_pkg::LINK_MODE_WAIT: begin
            if (w.rx_valid) begin
              decode(w, r);
              if (last_cmd == pend_cmd && (pend_cmd == mclr_pkg::CMD_STOP ||
                  pend_cmd == mclr_pkg::CMD_FORWARD || pend_cmd == mclr_pkg::CMD_REVERSE))
              begin
                resends = '0;
                ticks   = '0;
                mode    = mclr_pkg::LINK_MODE_RECEIVE;
                n_acked++;
              end
            end
            // counter still advances after a match
            ticks++;
            if (ticks >= timeout) begin
              ticks = '0;
              if (resends < retries) begin
                mode = mclr_pkg::LINK_MODE_SEND;
                resends++;
                n_resent++;
                transmit(r);
              end else begin
                mode      = mclr_pkg::LINK_MODE_RECEIVE;
                resends   = '0;
                r.gave_up = 1'b1;
                n_gave_up++;
              end
            end
          end
          default: mode = mclr_pkg::LINK_MODE_RECEIVE;
        endcase
      end
      r.link_mode    = mode;
      r.resend_count = resends;
      r.queued       = fill;
      r.last_cmd     = last_cmd;
      r.last_status  = last_st;
      r.last_length  = last_len;
      return r;
    endfunction

    function void note_word(logic func, mclr_pkg::link_in_t w);
      words_in++;
      due_results.push_back(advance_link(func, w));
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        if (mismatches < 10)
          $display("result %0d: %s expected 0x%02h, got 0x%02h",
                   words_out, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(mclr_pkg::link_out_t got);
      mclr_pkg::link_out_t exp;
      words_out++;
      if (due_results.size() == 0) begin
        if (mismatches < 10)
          $display("result %0d: unexpected word 0x%014h", words_out, got);
        mismatches++;
        return;
      end
      exp = due_results.pop_front();
      compare_field("send_valid",    8'(exp.send_valid),    8'(got.send_valid));
      compare_field("send_cmd",      exp.send_cmd,          got.send_cmd);
      compare_field("send_checksum", exp.send_checksum,     got.send_checksum);
      compare_field("key_report",    8'(exp.key_report),    8'(got.key_report));
      compare_field("link_mode",     8'(exp.link_mode),     8'(got.link_mode));
      compare_field("resend_count",  8'(exp.resend_count),  8'(got.resend_count));
      compare_field("queued",        8'(exp.queued),        8'(got.queued));
      compare_field("dropped",       8'(exp.dropped),       8'(got.dropped));
      compare_field("gave_up",       8'(exp.gave_up),       8'(got.gave_up));
      compare_field("last_cmd",      exp.last_cmd,          got.last_cmd);
      compare_field("last_status",   exp.last_status,       got.last_status);
      compare_field("last_length",   exp.last_length,       got.last_length);
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [31:0]                    s_tdata;
  logic                           s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [55:0]                    m_tdata;
  logic                           cfg_we;
  logic [mclr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                     cfg_data;

  link_scoreboard sb = new();
  int unsigned    cycles = 0;
  int             phases_run = 0;
  int             enq_pct = 35;

  motor_command_link_with_retry #(
    .QUEUE_DEPTH (16)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // handshake monitor: results are checked before the new word is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check_word(mclr_pkg::link_out_t'(m_tdata[54:0]));
      if (s_tvalid && s_tready)
        sb.note_word(s_tuser, mclr_pkg::link_in_t'(s_tdata[26:0]));
    end
  end

  // receiver: ready runs and stalls, plus one long hold-off to back up the input
  initial begin : receiver
    int  run_len;
    int  stall_len;
    bit  long_done;
    long_done = 1'b0;
    m_tready  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!long_done && sb.words_out >= 400) begin
        long_done = 1'b1;
        m_tready  = 1'b0;
        repeat (90) @(negedge clk);
      end else begin
        case ($urandom_range(0, 9))
          0:       run_len = $urandom_range(40, 100);
          1, 2:    run_len = $urandom_range(5, 40);
          default: run_len = $urandom_range(1, 4);
        endcase
        m_tready = 1'b1;
        repeat (run_len) @(negedge clk);
        if ($urandom_range(0, 99) < 85) stall_len = $urandom_range(1, 3);
        else stall_len = $urandom_range(8, 30);
        m_tready = 1'b0;
        repeat (stall_len) @(negedge clk);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic func, input mclr_pkg::link_in_t w);
    s_tuser  = func;
    s_tdata  = {5'b0, w};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(5, 25);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mclr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic enqueue(input logic [1:0] code);
    mclr_pkg::link_in_t w;
    logic [31:0]        raw;
    raw = $urandom;
    w = raw[26:0];
    w.command = code;
    send_word(mclr_pkg::FUNC_ENQUEUE, w);
  endtask

  task automatic tick(input logic rxv, input logic [7:0] len, input logic [7:0] cmd,
                      input logic [7:0] st);
    mclr_pkg::link_in_t w;
    w = '0;
    w.rx_valid  = rxv;
    w.rx_length = len;
    w.rx_cmd    = cmd;
    w.rx_status = st;
    send_word(mclr_pkg::FUNC_TICK, w);
  endtask

  // random word: an enqueue or a tick, biased toward acks for the pending command and well-formed packets
  task automatic random_word();
    mclr_pkg::link_in_t w;
    logic [31:0]        raw;
    int                 r;
    raw = $urandom;
    w = raw[26:0];
    if ($urandom_range(0, 99) < enq_pct) begin
      if ($urandom_range(0, 19) == 0) w.command = mclr_pkg::CODE_NONE;
      else w.command = 2'($urandom_range(0, 2));
      send_word(mclr_pkg::FUNC_ENQUEUE, w);
    end else begin
      w.rx_valid = ($urandom_range(0, 99) < 60);
      r = $urandom_range(0, 99);
      if (r < 45) w.rx_cmd = sb.pend_cmd;
      else if (r < 60) w.rx_cmd = sb.key;
      else if (r < 80) begin
        case ($urandom_range(0, 2))
          0:       w.rx_cmd = mclr_pkg::CMD_FORWARD;
          1:       w.rx_cmd = mclr_pkg::CMD_REVERSE;
          default: w.rx_cmd = mclr_pkg::CMD_STOP;
        endcase
      end
      if ($urandom_range(0, 3) != 0) w.rx_length = PKT_LEN;
      send_word(mclr_pkg::FUNC_TICK, w);
    end
    sender_gap();
  endtask

  initial begin : stimulus
    int unsigned tmo_set [7];
    int unsigned rty_set [7];
    int unsigned key_set [7];
    logic [7:0]  key_val;
    tmo_set = '{255, 0, 1, 4, 9, 100, 2};
    rty_set = '{15, 0, 15, 2, 5, 3, 1};
    key_set = '{8'hFF, 8'h11, 8'h13, 8'h00, 8'h00, 8'h12, 8'h00};
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = mclr_pkg::FUNC_ENQUEUE;
    cfg_we    = 1'b0;
    cfg_index = mclr_pkg::REG_TIMEOUT_TICKS;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset config, decode extremes, every command, ack and mismatch
    tick(1'b1, 8'hFF, 8'h00, 8'hFF);
    tick(1'b1, 8'h00, 8'hFF, 8'h00);
    enqueue(mclr_pkg::CODE_NONE);
    enqueue(mclr_pkg::CODE_STOP);
    enqueue(mclr_pkg::CODE_FORWARD);
    enqueue(mclr_pkg::CODE_REVERSE);
    tick(1'b0, 8'h00, 8'h00, 8'h00);
    tick(1'b0, 8'h00, 8'h00, 8'h00);
    tick(1'b1, PKT_LEN, mclr_pkg::CMD_FORWARD, 8'h5A);
    tick(1'b0, 8'h00, 8'h00, 8'h00);
    tick(1'b1, PKT_LEN, mclr_pkg::CMD_STOP, 8'hA5);
    tick(1'b1, PKT_LEN, mclr_pkg::CMD_REVERSE, 8'h01);

    // abandon with no retries
    write_reg(mclr_pkg::REG_TIMEOUT_TICKS, 8'd1);
    write_reg(mclr_pkg::REG_MAX_RETRIES, 8'd0);
    enqueue(mclr_pkg::CODE_FORWARD);
    tick(1'b0, 8'h00, 8'h00, 8'h00);
    tick(1'b0, 8'h00, 8'h00, 8'h00);

    // one resend then abandon; ack followed by an immediate resend
    write_reg(mclr_pkg::REG_MAX_RETRIES, 8'd1);
    enqueue(mclr_pkg::CODE_REVERSE);
    tick(1'b0, 8'h00, 8'h00, 8'h00);
    tick(1'b0, 8'h00, 8'h00, 8'h00);
    tick(1'b0, 8'h00, 8'h00, 8'h00);
    enqueue(mclr_pkg::CODE_FORWARD);
    tick(1'b0, 8'h00, 8'h00, 8'h00);
    tick(1'b1, PKT_LEN, mclr_pkg::CMD_FORWARD, 8'h00);

    // random phases, each under its own register setting
    foreach (tmo_set[p]) begin
      key_val = 8'(key_set[p]);
      if (p == 4 || p == 6) key_val = 8'($urandom_range(0, 255));
      write_reg(mclr_pkg::REG_TIMEOUT_TICKS, 8'(tmo_set[p]));
      write_reg(mclr_pkg::REG_MAX_RETRIES, 8'(rty_set[p]));
      write_reg(mclr_pkg::REG_KEY_CODE, key_val);
      enq_pct = $urandom_range(25, 50);
      phases_run++;
      repeat (PHASE_WORDS) random_word();
    end

    wait_idle();
    repeat (10) @(negedge clk);

    $display("covered %0d words, %0d results over %0d phases: %0d sends, %0d resends, %0d acks",
             sb.words_in, sb.words_out, phases_run, sb.n_sent, sb.n_resent, sb.n_acked);
    $display("queue drops %0d, abandoned commands %0d, key pulses %0d, mismatches %0d",
             sb.n_dropped, sb.n_gave_up, sb.n_keys, sb.mismatches);
    if (sb.mismatches == 0 && sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/mclr_pkg.sv
rtl/core/mclr_ram.sv
rtl/core/mclr_queue.sv
rtl/core/motor_command_link_with_retry.sv
bench/testbench.sv
